// ----- hdl/svpwm_pkg.sv -----
// shared constants for the min-max space-vector modulator
package svpwm_pkg;

    // phase voltages are carried as integers scaled by 2^VSCALE_BITS
    localparam int unsigned VSCALE_BITS = 28;

    // round(sqrt(3)/2 * 2^28)
    localparam logic [27:0] SQRT3_HALF_Q28 = 28'd232471924;

    // width of each duty word on the result port
    localparam int unsigned DUTY_W = 16;

endpackage

// ----- hdl/svpwm_front.sv -----
// inverse clarke, min-max offset, peak search and divisor selection (six stages)
module svpwm_front #(
    parameter int VOLT_WIDTH = 16,
    parameter int DW         = VOLT_WIDTH + 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [VOLT_WIDTH-1:0] bus_voltage,
    input  logic signed [VOLT_WIDTH-1:0] v_alpha,
    input  logic signed [VOLT_WIDTH-1:0] v_beta,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic        [DW-1:0]         num_a,
    output logic        [DW-1:0]         num_b,
    output logic        [DW-1:0]         num_c,
    output logic        [2:0]            neg,
    output logic        [DW-1:0]         den,
    output logic                         over,
    output logic                         bus_pos
);

    localparam int PW = DW;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic en1, en2, en3, en4, en5, en6;

    // per-stage advance: a stage loads when empty or when the next one loads
    assign en6      = !v6_reg || out_ready;
    assign en5      = !v5_reg || en6;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
        end
    end

    // stage 1: scaled alpha terms and the sqrt(3)/2 product
    logic signed [PW-1:0]            afull1_reg, ahalf1_reg, kb1_reg;
    logic signed [VOLT_WIDTH-1:0]    bus1_reg;
    logic signed [PW-1:0]            al_s;
    logic signed [28:0]              k_s;
    logic signed [VOLT_WIDTH+28:0]   kb_s;

    assign k_s  = $signed({1'b0, svpwm_pkg::SQRT3_HALF_Q28});
    assign kb_s = k_s * v_beta;
    assign al_s = PW'(v_alpha);

    always_ff @(posedge aclk) begin
        if (en1) begin
            afull1_reg <= al_s <<< svpwm_pkg::VSCALE_BITS;
            ahalf1_reg <= al_s <<< (svpwm_pkg::VSCALE_BITS - 1);
            kb1_reg    <= PW'(kb_s);
            bus1_reg   <= bus_voltage;
        end
    end

    // stage 2: phase voltages
    logic signed [PW-1:0]         ph0_2_reg, ph1_2_reg, ph2_2_reg;
    logic signed [VOLT_WIDTH-1:0] bus2_reg;

    always_ff @(posedge aclk) begin
        if (en2) begin
            ph0_2_reg <= afull1_reg;
            ph1_2_reg <= kb1_reg - ahalf1_reg;
            ph2_2_reg <= -ahalf1_reg - kb1_reg;
            bus2_reg  <= bus1_reg;
        end
    end

    // stage 3: largest and smallest phase
    logic signed [PW-1:0]         ph0_3_reg, ph1_3_reg, ph2_3_reg, hi3_reg, lo3_reg;
    logic signed [VOLT_WIDTH-1:0] bus3_reg;
    logic signed [PW-1:0]         hi_next, lo_next;

    always_comb begin
        hi_next = ph0_2_reg;
        lo_next = ph0_2_reg;
        if (ph1_2_reg > hi_next) hi_next = ph1_2_reg;
        if (ph1_2_reg < lo_next) lo_next = ph1_2_reg;
        if (ph2_2_reg > hi_next) hi_next = ph2_2_reg;
        if (ph2_2_reg < lo_next) lo_next = ph2_2_reg;
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            ph0_3_reg <= ph0_2_reg;
            ph1_3_reg <= ph1_2_reg;
            ph2_3_reg <= ph2_2_reg;
            hi3_reg   <= hi_next;
            lo3_reg   <= lo_next;
            bus3_reg  <= bus2_reg;
        end
    end

    // stage 4: twice the offset phase voltage, as magnitude and sign
    logic signed [PW-1:0]         m0, m1, m2;
    logic        [DW-1:0]         mag0_4_reg, mag1_4_reg, mag2_4_reg;
    logic        [2:0]            neg4_reg;
    logic signed [VOLT_WIDTH-1:0] bus4_reg;

    assign m0 = (ph0_3_reg - hi3_reg) + (ph0_3_reg - lo3_reg);
    assign m1 = (ph1_3_reg - hi3_reg) + (ph1_3_reg - lo3_reg);
    assign m2 = (ph2_3_reg - hi3_reg) + (ph2_3_reg - lo3_reg);

    always_ff @(posedge aclk) begin
        if (en4) begin
            mag0_4_reg <= m0[PW-1] ? DW'(-m0) : DW'(m0);
            mag1_4_reg <= m1[PW-1] ? DW'(-m1) : DW'(m1);
            mag2_4_reg <= m2[PW-1] ? DW'(-m2) : DW'(m2);
            neg4_reg   <= {m2[PW-1], m1[PW-1], m0[PW-1]};
            bus4_reg   <= bus3_reg;
        end
    end

    // stage 5: peak magnitude and the bus divisor
    logic [DW-1:0] mag0_5_reg, mag1_5_reg, mag2_5_reg, peak5_reg, busden5_reg;
    logic [2:0]    neg5_reg;
    logic          pos5_reg;
    logic [DW-1:0] peak_next;

    always_comb begin
        peak_next = mag0_4_reg;
        if (mag1_4_reg > peak_next) peak_next = mag1_4_reg;
        if (mag2_4_reg > peak_next) peak_next = mag2_4_reg;
    end

    always_ff @(posedge aclk) begin
        if (en5) begin
            mag0_5_reg  <= mag0_4_reg;
            mag1_5_reg  <= mag1_4_reg;
            mag2_5_reg  <= mag2_4_reg;
            neg5_reg    <= neg4_reg;
            peak5_reg   <= peak_next;
            busden5_reg <= DW'($unsigned(bus4_reg)) << svpwm_pkg::VSCALE_BITS;
            pos5_reg    <= !bus4_reg[VOLT_WIDTH-1] && (bus4_reg != '0);
        end
    end

    // stage 6: overmodulation test picks the divisor
    logic          over_next;
    logic [DW-1:0] num0_6_reg, num1_6_reg, num2_6_reg, den6_reg;
    logic [2:0]    neg6_reg;
    logic          over6_reg, pos6_reg;

    assign over_next = pos5_reg && (peak5_reg > busden5_reg);

    always_ff @(posedge aclk) begin
        if (en6) begin
            num0_6_reg <= mag0_5_reg;
            num1_6_reg <= mag1_5_reg;
            num2_6_reg <= mag2_5_reg;
            neg6_reg   <= neg5_reg;
            den6_reg   <= over_next ? peak5_reg : busden5_reg;
            over6_reg  <= over_next;
            pos6_reg   <= pos5_reg;
        end
    end

    assign out_valid = v6_reg;
    assign num_a     = num0_6_reg;
    assign num_b     = num1_6_reg;
    assign num_c     = num2_6_reg;
    assign neg       = neg6_reg;
    assign den       = den6_reg;
    assign over      = over6_reg;
    assign bus_pos   = pos6_reg;

endmodule

// ----- hdl/svpwm_div.sv -----
// pipelined restoring divider for three phases, one quotient bit per stage, then rounding
module svpwm_div #(
    parameter int DUTY_FRAC_BITS = 15,
    parameter int DW             = 48
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [DW-1:0]                     num_a,
    input  logic [DW-1:0]                     num_b,
    input  logic [DW-1:0]                     num_c,
    input  logic [2:0]                        neg,
    input  logic [DW-1:0]                     den,
    input  logic                              over,
    input  logic                              bus_pos,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [svpwm_pkg::DUTY_W-1:0]      duty_a,
    output logic [svpwm_pkg::DUTY_W-1:0]      duty_b,
    output logic [svpwm_pkg::DUTY_W-1:0]      duty_c,
    output logic                              overmodulated
);

    localparam int NS = DUTY_FRAC_BITS + 1;
    localparam int QW = DUTY_FRAC_BITS + 2;
    localparam int OW = svpwm_pkg::DUTY_W;
    localparam int SW = (QW > OW) ? QW : OW;
    localparam logic [QW-1:0] QMAX = QW'((64'd1 << DUTY_FRAC_BITS) - 64'd1);

    logic [DW-1:0] r_reg   [0:NS-1][0:2];
    logic [QW-1:0] q_reg   [0:NS-1][0:2];
    logic [DW-1:0] den_reg [0:NS-1];
    logic [2:0]    neg_reg [0:NS-1];
    logic          over_reg[0:NS-1];
    logic          pos_reg [0:NS-1];
    logic [NS-1:0] v_reg;
    logic [NS:0]   rdy;
    logic          vout_reg;

    assign rdy[NS]   = !vout_reg || out_ready;
    assign in_ready  = rdy[0];
    assign out_valid = vout_reg;

    // one quotient bit per stage
    for (genvar j = 0; j < NS; j++) begin : g_step
        logic [DW-1:0] rin  [0:2];
        logic [QW-1:0] qin  [0:2];
        logic [DW-1:0] dcur;
        logic          vin;

        assign rdy[j] = !v_reg[j] || rdy[j+1];

        if (j == 0) begin : g_first
            assign rin[0] = num_a;
            assign rin[1] = num_b;
            assign rin[2] = num_c;
            assign qin[0] = '0;
            assign qin[1] = '0;
            assign qin[2] = '0;
            assign dcur   = den;
            assign vin    = in_valid;
        end else begin : g_next
            for (genvar k = 0; k < 3; k++) begin : g_ph
                assign rin[k] = {r_reg[j-1][k][DW-2:0], 1'b0};
                assign qin[k] = {q_reg[j-1][k][QW-2:0], 1'b0};
            end
            assign dcur = den_reg[j-1];
            assign vin  = v_reg[j-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (rdy[j]) begin
                v_reg[j] <= vin;
            end
        end

        for (genvar k = 0; k < 3; k++) begin : g_sub
            always_ff @(posedge aclk) begin
                if (rdy[j]) begin
                    if (rin[k] >= dcur) begin
                        r_reg[j][k] <= rin[k] - dcur;
                        q_reg[j][k] <= qin[k] | QW'(1);
                    end else begin
                        r_reg[j][k] <= rin[k];
                        q_reg[j][k] <= qin[k];
                    end
                end
            end
        end

        if (j == 0) begin : g_side0
            always_ff @(posedge aclk) begin
                if (rdy[j]) begin
                    den_reg[j]  <= den;
                    neg_reg[j]  <= neg;
                    over_reg[j] <= over;
                    pos_reg[j]  <= bus_pos;
                end
            end
        end else begin : g_siden
            always_ff @(posedge aclk) begin
                if (rdy[j]) begin
                    den_reg[j]  <= den_reg[j-1];
                    neg_reg[j]  <= neg_reg[j-1];
                    over_reg[j] <= over_reg[j-1];
                    pos_reg[j]  <= pos_reg[j-1];
                end
            end
        end
    end

    // rounding, limit, sign and the output word register
    logic [OW-1:0] duty_next [0:2];

    for (genvar k = 0; k < 3; k++) begin : g_out
        logic [DW-1:0]        rr;
        logic [QW-1:0]        qr, lim;
        logic signed [SW-1:0] qs, ds;

        assign rr  = {r_reg[NS-1][k][DW-2:0], 1'b0};
        assign qr  = q_reg[NS-1][k] + QW'(rr >= den_reg[NS-1]);
        assign lim = (qr > QMAX) ? QMAX : qr;
        assign qs  = SW'(lim);
        assign ds  = neg_reg[NS-1][k] ? -qs : qs;
        assign duty_next[k] = pos_reg[NS-1] ? ds[OW-1:0] : '0;
    end

    logic [OW-1:0] da_reg, db_reg, dc_reg;
    logic          ov_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vout_reg <= 1'b0;
        end else if (rdy[NS]) begin
            vout_reg <= v_reg[NS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[NS]) begin
            da_reg <= duty_next[0];
            db_reg <= duty_next[1];
            dc_reg <= duty_next[2];
            ov_reg <= over_reg[NS-1] && pos_reg[NS-1];
        end
    end

    assign duty_a        = da_reg;
    assign duty_b        = db_reg;
    assign duty_c        = dc_reg;
    assign overmodulated = ov_reg;

endmodule

// ----- hdl/svpwm_min_max_modulator.sv -----
// top level of the min-max space-vector modulator
//
// Input channel s_*: one word holds the bus voltage and the alpha and beta
// commands, all signed at one voltage LSB. Result channel m_*: one word holds
// the three phase duties (signed Q1.DUTY_FRAC_BITS in 16 bits) and the
// overmodulation flag. Every input word gives exactly one result word.
// The pipeline has six stages of transform, offset, peak and divisor choice,
// one restoring-divider stage per quotient bit (DUTY_FRAC_BITS + 1), and a
// rounding and output register. The divider stages do one compare-subtract
// each, so a new word may enter every cycle until a stall fills every stage.
// When m_ready is low the pipeline holds; empty stages still fill, so
// s_ready drops only once every stage holds a word. Nothing is lost or
// repeated under stalls. Synchronous active-low reset empties the pipeline;
// there is no other state. A bus voltage of zero or less gives zero duties
// with the flag clear.
module svpwm_min_max_modulator #(
    parameter int VOLT_WIDTH     = 16,
    parameter int DUTY_FRAC_BITS = 15
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [VOLT_WIDTH-1:0]         s_bus_voltage,
    input  logic signed [VOLT_WIDTH-1:0]         s_v_alpha,
    input  logic signed [VOLT_WIDTH-1:0]         s_v_beta,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [svpwm_pkg::DUTY_W-1:0]  m_duty_a,
    output logic signed [svpwm_pkg::DUTY_W-1:0]  m_duty_b,
    output logic signed [svpwm_pkg::DUTY_W-1:0]  m_duty_c,
    output logic                                 m_overmodulated
);

    localparam int DW = VOLT_WIDTH + 32;

    logic          mid_valid, mid_ready, mid_over, mid_pos;
    logic [DW-1:0] mid_na, mid_nb, mid_nc, mid_den;
    logic [2:0]    mid_neg;
    logic [svpwm_pkg::DUTY_W-1:0] da, db, dc;

    // transform and divisor selection
    svpwm_front #(
        .VOLT_WIDTH (VOLT_WIDTH),
        .DW         (DW)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .bus_voltage (s_bus_voltage),
        .v_alpha     (s_v_alpha),
        .v_beta      (s_v_beta),
        .out_valid   (mid_valid),
        .out_ready   (mid_ready),
        .num_a       (mid_na),
        .num_b       (mid_nb),
        .num_c       (mid_nc),
        .neg         (mid_neg),
        .den         (mid_den),
        .over        (mid_over),
        .bus_pos     (mid_pos)
    );

    // normalising divider
    svpwm_div #(
        .DUTY_FRAC_BITS (DUTY_FRAC_BITS),
        .DW             (DW)
    ) u_div (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (mid_valid),
        .in_ready      (mid_ready),
        .num_a         (mid_na),
        .num_b         (mid_nb),
        .num_c         (mid_nc),
        .neg           (mid_neg),
        .den           (mid_den),
        .over          (mid_over),
        .bus_pos       (mid_pos),
        .out_valid     (m_valid),
        .out_ready     (m_ready),
        .duty_a        (da),
        .duty_b        (db),
        .duty_c        (dc),
        .overmodulated (m_overmodulated)
    );

    assign m_duty_a = $signed(da);
    assign m_duty_b = $signed(db);
    assign m_duty_c = $signed(dc);

endmodule

// ----- test/svpwm_min_max_checker.sv -----
// checker for the min-max modulator: predicts each result word and compares
module svpwm_min_max_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [15:0] s_bus_voltage,
    input  logic [15:0] s_v_alpha,
    input  logic [15:0] s_v_beta,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [15:0] m_duty_a,
    input  logic [15:0] m_duty_b,
    input  logic [15:0] m_duty_c,
    input  logic        m_overmodulated,
    output int          fail_count,
    output int          pending
);

    localparam int FRAC = 15;
    localparam int VSB  = svpwm_pkg::VSCALE_BITS;

    typedef struct packed {
        logic [15:0] duty_a;
        logic [15:0] duty_b;
        logic [15:0] duty_c;
        logic        over;
    } duty_word_t;

    duty_word_t duty_queue[$];

    // rounded ratio num * 2^FRAC / den, limited to full scale
    function automatic longint unsigned duty_ratio(longint unsigned num,
                                                   longint unsigned den);
        longint unsigned r, q;
        r = num;
        q = 0;
        if (r >= den) begin
            r -= den;
            q = 1;
        end
        for (int i = 0; i < FRAC; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r -= den;
                q |= 1;
            end
        end
        r = r << 1;
        if (r >= den) q += 1;
        if (q > (64'd1 << FRAC) - 1) q = (64'd1 << FRAC) - 1;
        return q;
    endfunction

    function automatic duty_word_t modulate(logic signed [15:0] vbus,
                                            logic signed [15:0] alpha,
                                            logic signed [15:0] beta);
        longint ph[3], m2[3], hi, lo, d, k3;
        longint unsigned peak, den, mg, q;
        duty_word_t w;
        logic [15:0] dw[3];
        w = '0;
        if (vbus <= 0) return w;
        k3 = longint'(svpwm_pkg::SQRT3_HALF_Q28);
        ph[0] = longint'(alpha) * (64'sd1 <<< VSB);
        ph[1] = -(longint'(alpha) * (64'sd1 <<< (VSB - 1))) + k3 * longint'(beta);
        ph[2] = -(longint'(alpha) * (64'sd1 <<< (VSB - 1))) - k3 * longint'(beta);
        hi = ph[0];
        lo = ph[0];
        for (int k = 1; k < 3; k++) begin
            if (ph[k] > hi) hi = ph[k];
            if (ph[k] < lo) lo = ph[k];
        end
        // twice the offset phase voltage and its peak
        peak = 0;
        for (int k = 0; k < 3; k++) begin
            m2[k] = (ph[k] - hi) + (ph[k] - lo);
            mg = (m2[k] < 0) ? -m2[k] : m2[k];
            if (mg > peak) peak = mg;
        end
        den = longint'(vbus) << VSB;
        if (peak > den) begin
            den = peak;
            w.over = 1'b1;
        end
        for (int k = 0; k < 3; k++) begin
            mg = (m2[k] < 0) ? -m2[k] : m2[k];
            q = duty_ratio(mg, den);
            d = (m2[k] < 0) ? -longint'(q) : longint'(q);
            dw[k] = d[15:0];
        end
        w.duty_a = dw[0];
        w.duty_b = dw[1];
        w.duty_c = dw[2];
        return w;
    endfunction

    assign pending = duty_queue.size();

    // predict on accepted input words, compare accepted result words
    always @(posedge aclk) begin
        duty_word_t want, got;
        if (!aresetn) begin
            duty_queue.delete();
            fail_count <= 0;
        end else begin
            if (s_valid && s_ready)
                duty_queue.push_back(modulate(s_bus_voltage, s_v_alpha, s_v_beta));
            if (m_valid && m_ready) begin
                got = {m_duty_a, m_duty_b, m_duty_c, m_overmodulated};
                if (duty_queue.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result word %h", got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = duty_queue.pop_front();
                    if (want !== got) begin
                        if (fail_count < 10)
                            $display("mismatch: exp a=%h b=%h c=%h ov=%b got a=%h b=%h c=%h ov=%b",
                                     want.duty_a, want.duty_b, want.duty_c, want.over,
                                     got.duty_a, got.duty_b, got.duty_c, got.over);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- test/svpwm_min_max_modulator_test.sv -----
// stimulus and verdict for the min-max modulator
module svpwm_min_max_modulator_test;
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_bus_voltage = '0;
    logic [15:0] s_v_alpha = '0;
    logic [15:0] s_v_beta = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_duty_a, m_duty_b, m_duty_c;
    logic        m_overmodulated;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    bit          stall_on = 1'b1;

    localparam int WATCHDOG = 5000;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    svpwm_min_max_modulator dut (.*);

    svpwm_min_max_checker checker_i (.*);

    // receiver stalls in runs of random length
    always @(negedge aclk) begin
        if (!stall_on) m_ready <= 1'b1;
        else if ($urandom_range(0, 7) == 0) m_ready <= ~m_ready;
        else if ($urandom_range(0, 3) == 0) m_ready <= 1'b1;
    end

    // watchdog on cycles with no accepted word
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_word(logic [15:0] vbus, logic [15:0] alpha, logic [15:0] beta);
        s_valid       <= 1'b1;
        s_bus_voltage <= vbus;
        s_v_alpha     <= alpha;
        s_v_beta      <= beta;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drop_valid();
        s_valid <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [15:0] rand_volt();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] vb, va, vbt;
        int burst;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed words: extremes, non-positive bus, zero command, overmodulation
        send_word(16'h0000, 16'h1234, 16'h4321);
        send_word(16'hffff, 16'h7fff, 16'h7fff);
        send_word(16'h8000, 16'h8000, 16'h8000);
        send_word(16'h7fff, 16'h0000, 16'h0000);
        send_word(16'h0001, 16'h0000, 16'h0000);
        send_word(16'h7fff, 16'h7fff, 16'h0000);
        send_word(16'h7fff, 16'h8000, 16'h7fff);
        send_word(16'h0001, 16'h7fff, 16'h8000);
        send_word(16'h0001, 16'h8000, 16'h8000);
        send_word(16'h0064, 16'h004b, 16'h0000);
        send_word(16'h0064, 16'h0064, 16'h0000);
        send_word(16'h0064, 16'h0032, 16'h0000);
        send_word(16'h0064, 16'h0000, 16'h0032);
        send_word(16'h0002, 16'h0001, 16'hffff);
        send_word(16'h4000, 16'h2000, 16'h1000);
        send_word(16'h0001, 16'h0001, 16'h0000);
        drop_valid();

        // hold off until the pipeline has drained
        while (pending != 0) @(negedge aclk);

        // random bursts with gaps; a stretch with no idling in the middle
        for (int n = 0; n < 1400; ) begin
            stall_on = !(n > 600 && n < 800);
            burst = $urandom_range(1, 40);
            for (int i = 0; i < burst; i++) begin
                vb = ($urandom_range(0, 9) == 0) ? rand_volt() : 16'($urandom_range(1, 32767));
                if ($urandom_range(0, 3) == 0) vb = 16'($urandom_range(1, 300));
                va = rand_volt();
                vbt = rand_volt();
                send_word(vb, va, vbt);
                n++;
            end
            if (stall_on) begin
                drop_valid();
                repeat ($urandom_range(0, 6)) @(negedge aclk);
            end
        end
        drop_valid();
        stall_on = 1'b1;

        while (pending != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        if (fail_count == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end
endmodule

// ----- sim.f -----
hdl/svpwm_pkg.sv
hdl/svpwm_front.sv
hdl/svpwm_div.sv
hdl/svpwm_min_max_modulator.sv
test/svpwm_min_max_checker.sv
test/svpwm_min_max_modulator_test.sv
